FILE: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the linear-probe hash table.
// No dependencies; imported by linear_probe_hash_table, lpht_ctrl and lpht_checker.
package lpht_pkg;

  localparam int DEF_TABLE_SLOTS = 64;
  localparam int KEY_W           = 31;
  localparam int VAL_W           = 32;
  localparam int ENTRY_W         = 7;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 2;
  localparam int MARK_W          = 2;
  localparam int IN_DATA_W       = 64;
  localparam int OUT_DATA_W      = 40;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  // One table slot as held in the slot memory.
  typedef struct packed {
    logic [MARK_W-1:0] mark;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Answer to one request, handed from the controller to the output stage.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [ENTRY_W-1:0]  entry_total;
  } result_t;

endpackage

FILE: rtl/linear_probe_hash_table.sv
`timescale 1ns / 1ps
// Linear-probe hash table with tombstones: slot memory, probe controller and result register.
// Depends on lpht_pkg, lpht_ram and lpht_ctrl.
//
// A request probes slots from its home slot up to the hit, the first empty slot or the
// whole table; the result register is loaded when the probe ends, and the next beat is
// taken once the controller is idle again. A request of the unused mode skips the probe.
// The slot memory has a single registered read port, read one slot per cycle while the
// result register is not stalled. After reset the block runs a clearing pass over the
// slot marks and holds in_tready low until it finishes.
// The result register lets a new beat be accepted while the previous result still waits
// on out_tready.
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // key [30:0], value [62:31], zero fill [63]
  input  logic [MODE_W-1:0]     in_tuser,   // mode [1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // read_value [31:0], entry_total [38:32], zero [39]
  output logic [STATUS_W-1:0]   out_tuser   // status [1:0]
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  logic             out_tvalid_r, out_tvalid_nxt;
  result_t          out_res_r, out_res_nxt;
  logic             out_busy;
  logic             res_valid;
  result_t          res;
  logic             ram_wr_en;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [SLOT_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [SLOT_W-1:0] ram_rd_data;

  assign out_busy = out_tvalid_r && !out_tready;

  lpht_ctrl #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_mode   (in_tuser),
    .req_key    (in_tdata[KEY_W-1:0]),
    .req_value  (in_tdata[KEY_W+VAL_W-1:KEY_W]),
    .out_busy   (out_busy),
    .res_valid  (res_valid),
    .res        (res),
    .ram_wr_en  (ram_wr_en),
    .ram_wr_addr(ram_wr_addr),
    .ram_wr_data(ram_wr_data),
    .ram_rd_en  (ram_rd_en),
    .ram_rd_addr(ram_rd_addr),
    .ram_rd_data(ram_rd_data)
  );

  lpht_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // The controller only offers a result when the register is free or being emptied.
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_res_nxt    = out_res_r;
    if (res_valid) begin
      out_tvalid_nxt = 1'b1;
      out_res_nxt    = res;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {1'b0, out_res_r.entry_total, out_res_r.read_value};

endmodule

FILE: rtl/lpht_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while rd_en is low.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/lpht_ctrl.sv
`timescale 1ns / 1ps
// Probe controller: clearing pass, slot probing and read-modify-write of the slot memory.
// Depends on lpht_pkg; drives the ports of one lpht_ram instance.
module lpht_ctrl
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic [MODE_W-1:0]              req_mode,
  input  logic [KEY_W-1:0]               req_key,
  input  logic [VAL_W-1:0]               req_value,
  input  logic                           out_busy,
  output logic                           res_valid,
  output result_t                        res,
  output logic                           ram_wr_en,
  output logic [$clog2(TABLE_SLOTS)-1:0] ram_wr_addr,
  output logic [SLOT_W-1:0]              ram_wr_data,
  output logic                           ram_rd_en,
  output logic [$clog2(TABLE_SLOTS)-1:0] ram_rd_addr,
  input  logic [SLOT_W-1:0]              ram_rd_data
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_NOP   = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic [IDX_W-1:0]   rd_addr_r, rd_addr_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_cnt_r, chk_cnt_nxt;
  logic               ff_vld_r, ff_vld_nxt;
  logic [IDX_W-1:0]   ff_idx_r, ff_idx_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;

  slot_t            slot;
  slot_t            wr_slot;
  logic             accept;
  logic             examine;
  logic             is_empty;
  logic             is_tomb;
  logic             is_hit;
  logic             is_last;
  logic             done;
  logic             free_vld;
  logic [IDX_W-1:0] free_idx;

  assign slot      = slot_t'(ram_rd_data);
  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;

  // A slot's data is examined after its read was issued, once out_busy is low.
  assign examine  = (state_r == ST_PROBE) && chk_vld_r && !out_busy;
  assign is_empty = (slot.mark == MARK_EMPTY);
  assign is_tomb  = (slot.mark == MARK_TOMB);
  assign is_hit   = (slot.mark == MARK_LIVE) && (slot.key == key_r);
  assign is_last  = (chk_cnt_r == IDX_W'(TABLE_SLOTS - 1));
  assign done     = examine && (is_empty || is_hit || is_last);
  assign free_vld = ff_vld_r || is_empty || is_tomb;
  assign free_idx = ff_vld_r ? ff_idx_r : chk_idx_r;

  // Reads run one slot ahead of the examination; a read past the end is simply discarded.
  assign ram_rd_en   = (state_r == ST_PROBE) && !out_busy;
  assign ram_rd_addr = rd_addr_r;
  assign ram_wr_data = SLOT_W'(wr_slot);

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    mode_nxt    = mode_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    rd_addr_nxt = rd_addr_r;
    chk_idx_nxt = chk_idx_r;
    chk_vld_nxt = chk_vld_r;
    chk_cnt_nxt = chk_cnt_r;
    ff_vld_nxt  = ff_vld_r;
    ff_idx_nxt  = ff_idx_r;
    live_nxt    = live_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = chk_idx_r;
    wr_slot     = '{mark: MARK_EMPTY, key: '0, value: '0};
    res_valid   = 1'b0;
    res.status     = STATUS_OK;
    res.read_value = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_idx_r;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(TABLE_SLOTS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          mode_nxt    = req_mode;
          key_nxt     = req_key;
          val_nxt     = req_value;
          rd_addr_nxt = req_key[IDX_W-1:0];
          chk_vld_nxt = 1'b0;
          chk_cnt_nxt = '0;
          ff_vld_nxt  = 1'b0;
          if (req_mode inside {MODE_LOOKUP, MODE_INSERT, MODE_DELETE}) begin
            state_nxt = ST_PROBE;
          end else begin
            state_nxt = ST_NOP;
          end
        end
      end
      ST_PROBE: begin
        if (!out_busy) begin
          rd_addr_nxt = rd_addr_r + IDX_W'(1);
          chk_idx_nxt = rd_addr_r;
          chk_vld_nxt = 1'b1;
        end
        if (examine) begin
          chk_cnt_nxt = chk_cnt_r + IDX_W'(1);
          if (is_tomb && !ff_vld_r) begin
            ff_vld_nxt = 1'b1;
            ff_idx_nxt = chk_idx_r;
          end
        end
        if (done) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
          case (mode_r)
            MODE_LOOKUP: begin
              if (is_hit) begin
                res.read_value = slot.value;
              end else begin
                res.status = STATUS_NOTFOUND;
              end
            end
            MODE_INSERT: begin
              wr_slot = '{mark: MARK_LIVE, key: key_r, value: val_r};
              if (is_hit) begin
                ram_wr_en = 1'b1;
              end else if (free_vld) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = free_idx;
                live_nxt    = live_r + CNT_W'(1);
              end else begin
                res.status = STATUS_FULL;
              end
            end
            MODE_DELETE: begin
              wr_slot = '{mark: MARK_TOMB, key: slot.key, value: slot.value};
              if (is_hit) begin
                ram_wr_en = 1'b1;
                live_nxt  = live_r - CNT_W'(1);
              end else begin
                res.status = STATUS_NOTFOUND;
              end
            end
            default: begin
              res.status = STATUS_OK;
            end
          endcase
        end
      end
      ST_NOP: begin
        if (!out_busy) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.entry_total = ENTRY_W'(live_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
      chk_vld_r <= 1'b0;
      ff_vld_r  <= 1'b0;
      live_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
      chk_vld_r <= chk_vld_nxt;
      ff_vld_r  <= ff_vld_nxt;
      live_r    <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    rd_addr_r <= rd_addr_nxt;
    chk_idx_r <= chk_idx_nxt;
    chk_cnt_r <= chk_cnt_nxt;
    ff_idx_r  <= ff_idx_nxt;
  end

endmodule

FILE: rtl/lpht_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the linear-probe hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
module lpht_checker
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [MODE_W-1:0]     in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn before it was taken");

  // One request at a time: no new beat is taken right after one was accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another was in progress");

  // Only a successful answer carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STATUS_OK |-> out_tdata[31:0] == 32'd0)
    else $error("non-zero value with a failure status");

  // The live count cannot exceed the table size (checked below 128 slots, for the 7-bit total).
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (TABLE_SLOTS >= 128) || (out_tdata[38:32] <= TABLE_SLOTS))
    else $error("entry total beyond table capacity");

endmodule

bind linear_probe_hash_table lpht_checker #(.TABLE_SLOTS(TABLE_SLOTS)) u_lpht_checker (.*);
